[hw/rtl/periodic_telemetry_rate_scheduler_top_defines.svh]
// Assertion macros for the periodic telemetry rate scheduler.
// The user scope must provide clk and rst_n; no other dependencies.
`ifndef PERIODIC_TELEMETRY_RATE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TELEMETRY_RATE_SCHEDULER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ptrs_pkg.sv]
// Shared types and constants for the periodic telemetry rate scheduler.
// No dependencies.
`default_nettype none

package ptrs_pkg;

  localparam int GROUPS    = 4;
  localparam int GRP_W     = 2;
  localparam int CNT_W     = 32;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int AG_W      = 3;

  localparam logic [CFG_AW-1:0] REG_START_TIME   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ACTIVE       = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PUBLISH_EN   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PUBLISH_MASK = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RATE0        = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RATE1        = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RATE2        = 3'd6;
  localparam logic [CFG_AW-1:0] REG_RATE3        = 3'd7;

  typedef enum logic [2:0] {
    ACT_NOT_DUE     = 3'd0,
    ACT_SENT        = 3'd1,
    ACT_UNPUBLISHED = 3'd2,
    ACT_DROPPED     = 3'd3,
    ACT_DEFERRED    = 3'd4
  } action_t;

  typedef struct packed {
    logic [31:0] current_tick;
    logic [3:0]  accept_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  group_index;
    action_t     action;
    logic [31:0] sent_total;
    logic [31:0] dropped_total;
    logic [31:0] unpublished_total;
    logic        last_of_pass;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] sent;
    logic [CNT_W-1:0] dropped;
    logic [CNT_W-1:0] unpub;
  } cnt_word_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [GRP_W-1:0] addr;
    cnt_word_t        wdata;
  } mem_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_stat_t;

endpackage

`default_nettype wire

[hw/rtl/ptrs_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ptrs_pkg.
`default_nettype none

module ptrs_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptrs_pkg::div_req_t  req,
  output ptrs_pkg::div_stat_t      stat
);

  logic                              busy_r;
  logic                              done_r;
  logic [ptrs_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [ptrs_pkg::DIV_W:0]          rem_r;
  logic [ptrs_pkg::DIV_W-1:0]        quo_r;
  logic [ptrs_pkg::DIV_W-1:0]        dvs_r;
  logic [ptrs_pkg::DIV_W:0]          shifted;
  logic [ptrs_pkg::DIV_W+1:0]        diff;
  logic                              ge;

  assign shifted = {rem_r[ptrs_pkg::DIV_W-1:0], quo_r[ptrs_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = ~diff[ptrs_pkg::DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ptrs_pkg::DIV_CNT_W'(ptrs_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[ptrs_pkg::DIV_W:0] : shifted;
      quo_r <= {quo_r[ptrs_pkg::DIV_W-2:0], ge};
    end
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule

`default_nettype wire

[hw/rtl/ptrs_cnt_mem.sv]
// Per-group counter memory with registered read and reset-cleared valid bits.
// Depends on ptrs_pkg.
`default_nettype none

module ptrs_cnt_mem (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptrs_pkg::mem_req_t  req,
  output ptrs_pkg::cnt_word_t      rd_data
);

  ptrs_pkg::cnt_word_t        mem [ptrs_pkg::GROUPS];
  logic [ptrs_pkg::GROUPS-1:0] vld_r;
  ptrs_pkg::cnt_word_t        rd_q_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

[hw/rtl/periodic_telemetry_rate_scheduler_top.sv]
// Top level of the periodic telemetry rate scheduler: registers, sequencer, output stage.
// Depends on ptrs_pkg, ptrs_div, ptrs_cnt_mem and the assertion macro header.
//
//   Port group   Direction   Handshake            Content
//   in_          input       in_valid/in_ready    in_item_t service pass
//   out_         output      out_valid/out_ready  out_item_t result per group
//   cfg_         input       cfg_we               register index and write data
//
// Each active group goes through these steps: start the divider and read the
// counter memory, wait for the divider, decide and write back, then emit.
// Reset is synchronous and clears control state and counter valid bits at once.
// A stalled output holds the sequencer in its emit step; a pass with no active
// groups is accepted and gives no items.
`default_nettype none
`include "periodic_telemetry_rate_scheduler_top_defines.svh"

module periodic_telemetry_rate_scheduler_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire ptrs_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output ptrs_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [ptrs_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire logic [ptrs_pkg::CFG_DW-1:0]       cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t                           state_r;
  logic [31:0]                      start_time_r;
  logic [ptrs_pkg::AG_W-1:0]        active_groups_r;
  logic                             publish_enable_r;
  logic [ptrs_pkg::GROUPS-1:0]      publish_mask_r;
  logic [31:0]                      rate_r [ptrs_pkg::GROUPS];

  logic [31:0]                      elapsed_r;
  logic [ptrs_pkg::GROUPS-1:0]      accept_r;
  logic [ptrs_pkg::GRP_W-1:0]       grp_r;
  logic [ptrs_pkg::AG_W-1:0]        grp_cnt_r;
  ptrs_pkg::out_item_t              res_r;
  ptrs_pkg::out_item_t              res_nxt;
  logic                             out_valid_r;
  ptrs_pkg::out_item_t              out_data_r;

  logic [ptrs_pkg::AG_W-1:0]        act_cnt;
  logic                             in_fire;
  logic                             emit_fire;
  logic [31:0]                      cur_rate;
  logic [31:0]                      handled;
  logic [31:0]                      due;
  logic [31:0]                      gap;
  logic                             is_due;
  logic                             published;
  ptrs_pkg::cnt_word_t              cnt_rd;
  ptrs_pkg::cnt_word_t              cnt_nxt;
  ptrs_pkg::mem_req_t               mem_req;
  ptrs_pkg::div_req_t               div_req;
  ptrs_pkg::div_stat_t              div_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r     <= '0;
      active_groups_r  <= '0;
      publish_enable_r <= 1'b1;
      publish_mask_r   <= '0;
      rate_r[0]        <= '0;
      rate_r[1]        <= '0;
      rate_r[2]        <= '0;
      rate_r[3]        <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ptrs_pkg::REG_START_TIME:   start_time_r     <= cfg_wdata;
        ptrs_pkg::REG_ACTIVE:       active_groups_r  <= cfg_wdata[ptrs_pkg::AG_W-1:0];
        ptrs_pkg::REG_PUBLISH_EN:   publish_enable_r <= cfg_wdata[0];
        ptrs_pkg::REG_PUBLISH_MASK: publish_mask_r   <= cfg_wdata[ptrs_pkg::GROUPS-1:0];
        ptrs_pkg::REG_RATE0:        rate_r[0]        <= cfg_wdata;
        ptrs_pkg::REG_RATE1:        rate_r[1]        <= cfg_wdata;
        ptrs_pkg::REG_RATE2:        rate_r[2]        <= cfg_wdata;
        ptrs_pkg::REG_RATE3:        rate_r[3]        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign act_cnt  = (active_groups_r > ptrs_pkg::AG_W'(ptrs_pkg::GROUPS))
                    ? ptrs_pkg::AG_W'(ptrs_pkg::GROUPS) : active_groups_r;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign cur_rate = rate_r[grp_r];

  assign div_req.start    = (state_r == S_START);
  assign div_req.dividend = elapsed_r;
  assign div_req.divisor  = cur_rate;

  ptrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  assign mem_req.rd_en = (state_r == S_START);
  assign mem_req.wr_en = (state_r == S_DECIDE);
  assign mem_req.addr  = grp_r;
  assign mem_req.wdata = cnt_nxt;

  ptrs_cnt_mem u_cnt_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (cnt_rd)
  );

  assign handled   = cnt_rd.sent + cnt_rd.dropped + cnt_rd.unpub;
  assign due       = (cur_rate != '0) ? div_stat.quotient : '0;
  assign gap       = due - handled;
  assign is_due    = (cur_rate != '0) && (due > handled);
  assign published = publish_enable_r && publish_mask_r[grp_r];

  always_comb begin
    cnt_nxt        = cnt_rd;
    res_nxt.action = ptrs_pkg::ACT_NOT_DUE;
    if (is_due) begin
      if (!published) begin
        cnt_nxt.unpub  = cnt_rd.unpub + 1'b1;
        res_nxt.action = ptrs_pkg::ACT_UNPUBLISHED;
      end else if (accept_r[grp_r]) begin
        cnt_nxt.sent   = cnt_rd.sent + 1'b1;
        res_nxt.action = ptrs_pkg::ACT_SENT;
      end else if (gap > 32'd1) begin
        cnt_nxt.dropped = cnt_rd.dropped + 1'b1;
        res_nxt.action  = ptrs_pkg::ACT_DROPPED;
      end else begin
        res_nxt.action = ptrs_pkg::ACT_DEFERRED;
      end
    end
    res_nxt.group_index       = grp_r;
    res_nxt.sent_total        = cnt_nxt.sent;
    res_nxt.dropped_total     = cnt_nxt.dropped;
    res_nxt.unpublished_total = cnt_nxt.unpub;
    res_nxt.last_of_pass      = (({1'b0, grp_r} + 1'b1) == grp_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            elapsed_r <= in_data.current_tick - start_time_r;
            accept_r  <= in_data.accept_mask;
            grp_r     <= '0;
            grp_cnt_r <= act_cnt;
            state_r   <= (act_cnt == '0) ? S_IDLE : S_START;
          end
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_stat.done) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_r   <= res_nxt;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            if (res_r.last_of_pass) begin
              state_r <= S_IDLE;
            end else begin
              grp_r   <= grp_r + 1'b1;
              state_r <= S_START;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PTRS_ASSERT_IMP(a_div_done_in_wait, div_stat.done, state_r == S_WAIT,
                   "divider finished outside wait")
  `PTRS_ASSERT_IMP(a_wr_div_idle, mem_req.wr_en, !div_stat.busy,
                   "counter write while dividing")
  `PTRS_ASSERT_NXT(a_zero_rate, (state_r == S_DECIDE) && (cur_rate == '0),
                   res_r.action == ptrs_pkg::ACT_NOT_DUE, "zero rate group marked due")

endmodule

`default_nettype wire
